@@ rtl/racs_pkg.sv @@
// Package for the range add / copy / sum engine: defaults, command codes, sequencer states.
`timescale 1ns / 1ps
package racs_pkg;

    localparam int DEPTH_DEF      = 1024;
    localparam int BLOCK_SIZE_DEF = 32;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_COPY  = 2'd2,
        CMD_QUERY = 2'd3
    } t_cmd;

    typedef enum logic [4:0] {
        S_CLR,
        S_IDLE,
        S_DIV,
        S_WR_RD,
        S_WR_EX,
        S_AQ_RD,
        S_AQ_EX,
        S_AQ_MUL,
        S_CS_RD,
        S_CS_EX,
        S_CF_INIT,
        S_CF_RD,
        S_CF_EX,
        S_CW_RD,
        S_CW_EX,
        S_CR_RD,
        S_CR_EX,
        S_DONE
    } t_state;

endpackage

@@ rtl/range_add_copy_sum_engine_unit.sv @@
// Top level of the range add / copy / sum engine over blocked 64-bit elements.
`timescale 1ns / 1ps
// Usage:
//  Input channel i_valid/o_ready carries one request: command, left, right,
//  source_left, source_right, value. Output channel o_valid/i_ready returns one
//  result per request: range_sum (zero unless a query) and status (1 = rejected).
//  Elements live in a RAM; each block of BLOCK_SIZE elements has a sum and a
//  pending add in small RAMs. A sequencer walks the elements, a read state and
//  an execute state each, through a shared read/modify/write path; whole blocks
//  inside an add or query range use the block RAMs (a query adds a multiply).
//  Block/offset of a start index: reciprocal multiply, then offset.
//  One request at a time: o_ready is high only in the idle state that follows
//  each result. A new request is taken while a result still waits in the output
//  register, and the sequencer holds in its done state while the receiver
//  stalls with a result pending.
//  Reset: a clearing pass over all DEPTH addresses zeroes the element, sum and
//  pending RAMs; o_ready stays low meanwhile.
module range_add_copy_sum_engine_unit #(
    parameter int DEPTH      = racs_pkg::DEPTH_DEF,
    parameter int BLOCK_SIZE = racs_pkg::BLOCK_SIZE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_command,
    input  logic [9:0]         i_left,
    input  logic [9:0]         i_right,
    input  logic [9:0]         i_source_left,
    input  logic [9:0]         i_source_right,
    input  logic signed [63:0] i_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [63:0] o_range_sum,
    output logic               o_status
);
    import racs_pkg::*;

    localparam int NB  = (DEPTH + BLOCK_SIZE - 1) / BLOCK_SIZE;
    localparam int AW  = $clog2(DEPTH);
    localparam int IW  = ($clog2(DEPTH + 1) > 10) ? $clog2(DEPTH + 1) : 10;
    localparam int BW  = (NB > 1) ? $clog2(NB) : 1;
    localparam int OW  = $clog2(BLOCK_SIZE);
    localparam int CNW = $clog2(BLOCK_SIZE + 1);
    localparam int RSH = IW + OW;

    localparam logic [IW-1:0] DEPTH_I  = IW'(DEPTH);
    localparam logic [IW-1:0] LAST_I   = IW'(DEPTH - 1);
    localparam logic [IW-1:0] NB_I     = IW'(NB);
    localparam logic [IW-1:0] BS_I     = IW'(BLOCK_SIZE);
    localparam logic [OW-1:0] OFF_LAST = OW'(BLOCK_SIZE - 1);
    localparam logic [IW:0]   BS_M1    = (IW + 1)'(BLOCK_SIZE - 1);
    localparam logic [IW:0]   LAST_W   = (IW + 1)'(DEPTH - 1);
    // ceil(2^RSH / BLOCK_SIZE): exact quotient for every IW-bit index
    localparam logic [IW:0]   RCP      = (IW + 1)'(((longint'(1) << RSH) +
                                         longint'(BLOCK_SIZE) - 1) / longint'(BLOCK_SIZE));

    // storage
    logic [63:0] elem_mem [0:DEPTH-1];
    logic [63:0] snap_mem [0:DEPTH-1];
    logic [63:0] bsum_mem [0:NB-1];
    logic [63:0] pend_mem [0:NB-1];

    logic [63:0] elem_rd, snap_rd, bsum_rd, pend_rd;
    logic          elem_we, snap_we, bsum_we, pend_we;
    logic [AW-1:0] elem_wa, snap_wa;
    logic [BW-1:0] bsum_wa, pend_wa;
    logic [63:0]   elem_wd, snap_wd, bsum_wd, pend_wd;

    // sequencer registers
    t_state        r_state, n_state, r_ret, n_ret;
    t_cmd          r_cmd, n_cmd;
    logic [IW-1:0] r_l, n_l, r_r, n_r, r_sr, n_sr;
    logic [63:0]   r_v, n_v;
    logic [IW-1:0] r_i, n_i, r_k, n_k, r_first, n_first, r_cnt, n_cnt;
    logic [BW-1:0] r_blk, n_blk, r_bl, n_bl;
    logic [OW-1:0] r_off, n_off;
    logic [63:0]   r_acc, n_acc, r_prod, n_prod, r_bsv, n_bsv;
    logic          r_bad, n_bad;
    logic [IW-1:0] r_dq, n_dq;
    logic          r_dcnt, n_dcnt;
    logic          r_ovalid, n_ovalid;
    logic [63:0]   r_osum, n_osum;
    logic          r_ostat, n_ostat;

    // helpers
    logic [IW-1:0] in_l, in_r, in_sl, in_sr, step_i;
    logic [IW:0]   e_tmp;
    logic [IW-1:0] e_idx;
    logic [CNW-1:0] cnt;
    logic          full, blk_end, in_bad;
    logic [OW-1:0] step_off;
    logic [BW-1:0] step_blk;
    logic [2*IW:0] q_prod;
    logic [IW-1:0] q_nx, off_full;
    logic [OW-1:0] off_nx;
    logic [63:0]   nv, acc_nx;

    always_ff @(posedge i_clk) begin
        if (elem_we) elem_mem[elem_wa] <= elem_wd;
        elem_rd <= elem_mem[r_i[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (snap_we) snap_mem[snap_wa] <= snap_wd;
        snap_rd <= snap_mem[r_k[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (bsum_we) bsum_mem[bsum_wa] <= bsum_wd;
        bsum_rd <= bsum_mem[r_blk];
    end

    always_ff @(posedge i_clk) begin
        if (pend_we) pend_mem[pend_wa] <= pend_wd;
        pend_rd <= pend_mem[r_blk];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret <= n_ret;   r_cmd <= n_cmd;   r_l <= n_l;     r_r <= n_r;
        r_sr <= n_sr;     r_v <= n_v;       r_i <= n_i;     r_k <= n_k;
        r_first <= n_first; r_blk <= n_blk; r_bl <= n_bl;   r_off <= n_off;
        r_acc <= n_acc;   r_prod <= n_prod; r_bsv <= n_bsv; r_bad <= n_bad;
        r_dq <= n_dq;     r_dcnt <= n_dcnt;
        r_osum <= n_osum; r_ostat <= n_ostat;
    end

    // block geometry at r_i
    assign in_l    = IW'(i_left);
    assign in_r    = IW'(i_right);
    assign in_sl   = IW'(i_source_left);
    assign in_sr   = IW'(i_source_right);
    assign e_tmp   = {1'b0, r_i} + BS_M1;
    assign e_idx   = (e_tmp > LAST_W) ? LAST_I : e_tmp[IW-1:0];
    assign cnt     = CNW'(e_idx - r_i + IW'(1));
    assign full    = (r_off == '0) && (e_idx <= r_r);
    assign blk_end = (r_off == OFF_LAST) || (r_i == LAST_I);
    assign step_i  = r_i + IW'(1);
    assign step_off = (r_off == OFF_LAST) ? '0 : r_off + OW'(1);
    assign step_blk = (r_off == OFF_LAST) ? r_blk + BW'(1) : r_blk;

    // block index by reciprocal multiply, offset from the registered quotient
    assign q_prod   = (2 * IW + 1)'(r_i) * (2 * IW + 1)'(RCP);
    assign q_nx     = IW'(q_prod[2*IW:RSH]);
    assign off_full = r_i - r_dq * BS_I;
    assign off_nx   = off_full[OW-1:0];

    assign nv     = r_v - pend_rd;
    assign acc_nx = r_acc + elem_rd;

    always_comb begin
        in_bad = 1'b0;
        if (i_command == CMD_WRITE) begin
            in_bad = (in_l >= DEPTH_I);
        end else if (in_l > in_r || in_r >= DEPTH_I) begin
            in_bad = 1'b1;
        end else if (i_command == CMD_COPY) begin
            in_bad = (in_sl > in_sr) || (in_sr >= DEPTH_I) ||
                     ((in_sr - in_sl) != (in_r - in_l));
        end
    end

    always_comb begin
        n_state = r_state; n_ret = r_ret; n_cmd = r_cmd; n_l = r_l; n_r = r_r;
        n_sr = r_sr; n_v = r_v; n_i = r_i; n_k = r_k; n_first = r_first;
        n_blk = r_blk; n_bl = r_bl; n_off = r_off; n_acc = r_acc;
        n_prod = r_prod; n_bsv = r_bsv; n_bad = r_bad; n_dq = r_dq;
        n_dcnt = r_dcnt; n_cnt = r_cnt;
        n_osum = r_osum; n_ostat = r_ostat;
        n_ovalid = r_ovalid && !i_ready;
        o_ready = 1'b0;
        elem_we = 1'b0; elem_wa = r_i[AW-1:0]; elem_wd = '0;
        snap_we = 1'b0; snap_wa = r_k[AW-1:0]; snap_wd = '0;
        bsum_we = 1'b0; bsum_wa = r_blk;       bsum_wd = '0;
        pend_we = 1'b0; pend_wa = r_blk;       pend_wd = '0;

        case (r_state)
            S_CLR: begin
                elem_we = 1'b1;
                elem_wa = r_cnt[AW-1:0];
                bsum_wa = r_cnt[BW-1:0];
                pend_wa = r_cnt[BW-1:0];
                bsum_we = (r_cnt < NB_I);
                pend_we = (r_cnt < NB_I);
                n_cnt   = r_cnt + IW'(1);
                if (r_cnt == LAST_I) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_cmd  = t_cmd'(i_command);
                    n_l    = in_l;
                    n_r    = in_r;
                    n_sr   = in_sr;
                    n_v    = i_value;
                    n_acc  = '0;
                    n_k    = '0;
                    n_bad  = in_bad;
                    n_dcnt = 1'b0;
                    n_dq   = (i_command == CMD_COPY) ? in_sl : in_l;
                    n_i    = n_dq;
                    case (i_command)
                        CMD_WRITE: n_ret = S_WR_RD;
                        CMD_COPY:  n_ret = S_CS_RD;
                        default:   n_ret = S_AQ_RD;
                    endcase
                    n_state = in_bad ? S_DONE : S_DIV;
                end
            end
            S_DIV: begin
                // quotient registered into r_dq, then block and offset from the registered quotient
                n_dq   = q_nx;
                n_dcnt = 1'b1;
                if (r_dcnt) begin
                    n_blk   = r_dq[BW-1:0];
                    n_off   = off_nx;
                    n_state = r_ret;
                end
            end
            S_WR_RD: n_state = S_WR_EX;
            S_WR_EX: begin
                elem_we = 1'b1;
                elem_wd = nv;
                bsum_we = 1'b1;
                bsum_wd = bsum_rd + nv - elem_rd;
                n_state = S_DONE;
            end
            S_AQ_RD: n_state = (r_i > r_r) ? S_DONE : S_AQ_EX;
            S_AQ_EX: begin
                if (full) begin
                    if (r_cmd == CMD_ADD) begin
                        pend_we = 1'b1;
                        pend_wd = pend_rd + r_v;
                        n_state = S_AQ_RD;
                    end else begin
                        n_prod  = pend_rd * 64'(cnt);
                        n_bsv   = bsum_rd;
                        n_state = S_AQ_MUL;
                    end
                    n_i   = e_idx + IW'(1);
                    n_off = '0;
                    n_blk = r_blk + BW'(1);
                end else begin
                    if (r_cmd == CMD_ADD) begin
                        elem_we = 1'b1;
                        elem_wd = elem_rd + r_v;
                        bsum_we = 1'b1;
                        bsum_wd = bsum_rd + r_v;
                    end else begin
                        n_acc = acc_nx + pend_rd;
                    end
                    n_i     = step_i;
                    n_off   = step_off;
                    n_blk   = step_blk;
                    n_state = S_AQ_RD;
                end
            end
            S_AQ_MUL: begin
                n_acc   = r_acc + r_bsv + r_prod;
                n_state = S_AQ_RD;
            end
            S_CS_RD: begin
                if (r_i > r_sr) begin
                    n_dq    = r_l;
                    n_i     = r_l;
                    n_dcnt  = 1'b0;
                    n_ret   = S_CF_INIT;
                    n_state = S_DIV;
                end else begin
                    n_state = S_CS_EX;
                end
            end
            S_CS_EX: begin
                snap_we = 1'b1;
                snap_wd = elem_rd + pend_rd;
                n_k     = r_k + IW'(1);
                n_i     = step_i;
                n_off   = step_off;
                n_blk   = step_blk;
                n_state = S_CS_RD;
            end
            S_CF_INIT: begin
                n_first = r_i - IW'(r_off);
                n_i     = r_i - IW'(r_off);
                n_bl    = r_blk;
                n_off   = '0;
                n_state = S_CF_RD;
            end
            S_CF_RD: n_state = S_CF_EX;
            S_CF_EX: begin
                // fold the block's pending add into each element, clear at block end
                elem_we = 1'b1;
                elem_wd = elem_rd + pend_rd;
                n_i     = step_i;
                n_off   = step_off;
                n_blk   = step_blk;
                n_state = S_CF_RD;
                if (blk_end) begin
                    pend_we = 1'b1;
                    pend_wd = '0;
                    if (step_i > r_r) begin
                        n_i     = r_l;
                        n_k     = '0;
                        n_state = S_CW_RD;
                    end
                end
            end
            S_CW_RD: begin
                if (r_i > r_r) begin
                    n_i     = r_first;
                    n_blk   = r_bl;
                    n_off   = '0;
                    n_acc   = '0;
                    n_state = S_CR_RD;
                end else begin
                    n_state = S_CW_EX;
                end
            end
            S_CW_EX: begin
                elem_we = 1'b1;
                elem_wd = snap_rd;
                n_i     = step_i;
                n_k     = r_k + IW'(1);
                n_state = S_CW_RD;
            end
            S_CR_RD: n_state = S_CR_EX;
            S_CR_EX: begin
                n_acc   = acc_nx;
                n_i     = step_i;
                n_off   = step_off;
                n_blk   = step_blk;
                n_state = S_CR_RD;
                if (blk_end) begin
                    bsum_we = 1'b1;
                    bsum_wd = acc_nx;
                    n_acc   = '0;
                    if (step_i > r_r) n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_osum   = (r_cmd == CMD_QUERY && !r_bad) ? r_acc : '0;
                    n_ostat  = r_bad;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_valid     = r_ovalid;
    assign o_range_sum = $signed(r_osum);
    assign o_status    = r_ostat;

    // checks
    a_clr_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !o_ready)
        else $error("ready during clearing pass");
    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (o_range_sum == '0))
        else $error("rejected request carries a sum");
    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready right after accepting a request");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_range_sum) && $stable(o_status)))
        else $error("stalled result changed");

endmodule

@@ dv/tb_range_add_copy_sum_engine_unit.sv @@
// Self-checking testbench for the range add / copy / sum engine.
`timescale 1ns / 1ps
module tb_range_add_copy_sum_engine_unit;
    import racs_pkg::*;

    localparam int DEPTH = 1024;
    localparam int BSZ   = 32;
    localparam int NBLK  = (DEPTH + BSZ - 1) / BSZ;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [1:0]         i_command;
    logic [9:0]         i_left;
    logic [9:0]         i_right;
    logic [9:0]         i_source_left;
    logic [9:0]         i_source_right;
    logic signed [63:0] i_value;
    logic               o_valid;
    logic               i_ready;
    logic signed [63:0] o_range_sum;
    logic               o_status;

    range_add_copy_sum_engine_unit dut (.*);

    // Predictor state: mirrors the blocked array with lazy adds.
    logic [63:0] elem_mem [DEPTH];
    logic [63:0] blk_sum [NBLK];
    logic [63:0] blk_pend [NBLK];

    typedef struct packed {
        logic [63:0] sum;
        logic        status;
    } t_result;

    t_result     expected_q[$];
    int          mismatches;
    int          results_seen;
    int          requests_sent;
    int          hold_cycles;   // receiver hold-off, driven by pressure test
    int          bad_seen;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic int blk_end(int b);
        int e;
        e = b * BSZ + BSZ - 1;
        return (e >= DEPTH) ? DEPTH - 1 : e;
    endfunction

    function automatic logic [63:0] value_at(int i);
        return elem_mem[i] + blk_pend[i / BSZ];
    endfunction

    // Compute the expected result of one request and update the model state.
    function automatic t_result predict_request(t_cmd cmd, int l, int r, int sl, int sr,
                                                logic [63:0] v);
        t_result     res;
        logic [63:0] snap [DEPTH];
        logic [63:0] acc;
        logic [63:0] p;
        int          i;
        int          b;
        int          e;
        int          n;
        res = '0;
        if (cmd == CMD_WRITE) begin
            b = l / BSZ;
            p = v - blk_pend[b];
            blk_sum[b] += p - elem_mem[l];
            elem_mem[l] = p;
        end else if (l > r) begin
            res.status = 1'b1;
        end else if (cmd == CMD_ADD) begin
            i = l;
            while (i <= r) begin
                b = i / BSZ;
                e = blk_end(b);
                if (i == b * BSZ && e <= r) begin
                    blk_pend[b] += v;
                    i = e + 1;
                end else begin
                    elem_mem[i] += v;
                    blk_sum[b] += v;
                    i++;
                end
            end
        end else if (cmd == CMD_COPY) begin
            if (sl > sr || (sr - sl) != (r - l)) begin
                res.status = 1'b1;
            end else begin
                n = r - l + 1;
                for (int k = 0; k < n; k++) snap[k] = value_at(sl + k);
                for (int bb = l / BSZ; bb <= r / BSZ; bb++) begin
                    for (int j = bb * BSZ; j <= blk_end(bb); j++) elem_mem[j] += blk_pend[bb];
                    blk_pend[bb] = '0;
                end
                for (int k = 0; k < n; k++) elem_mem[l + k] = snap[k];
                for (int bb = l / BSZ; bb <= r / BSZ; bb++) begin
                    acc = '0;
                    for (int j = bb * BSZ; j <= blk_end(bb); j++) acc += elem_mem[j];
                    blk_sum[bb] = acc;
                end
            end
        end else begin
            acc = '0;
            i = l;
            while (i <= r) begin
                b = i / BSZ;
                e = blk_end(b);
                if (i == b * BSZ && e <= r) begin
                    acc += blk_sum[b] + blk_pend[b] * 64'(e - i + 1);
                    i = e + 1;
                end else begin
                    acc += value_at(i);
                    i++;
                end
            end
            res.sum = acc;
        end
        return res;
    endfunction

    // Offer one request after a random gap; hold it until accepted.
    task automatic send_request(t_cmd cmd, int l, int r, int sl, int sr, logic [63:0] v,
                                bit no_gap = 0);
        int gap;
        t_result res;
        gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18));
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_command      <= cmd;
        i_left         <= 10'(l);
        i_right        <= 10'(r);
        i_source_left  <= 10'(sl);
        i_source_right <= 10'(sr);
        i_value        <= v;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        res = predict_request(cmd, l, r, sl, sr, v);
        expected_q.push_back(res);
        bad_seen += res.status;
        requests_sent++;
    endtask

    function automatic logic [63:0] rand64();
        case ($urandom_range(0, 4))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7fff_ffff_ffff_ffff;
            2: return 64'(int'($urandom_range(0, 200)) - 100);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Random request, mostly well formed, with small ranges favored.
    task automatic send_random();
        t_cmd cmd;
        int   l;
        int   r;
        int   sl;
        int   len;
        cmd = t_cmd'($urandom_range(0, 3));
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 200) : $urandom_range(1, 40);
        l   = $urandom_range(0, DEPTH - len);
        r   = l + len - 1;
        sl  = $urandom_range(0, DEPTH - len);
        case ($urandom_range(0, 19))
            0: send_request(cmd, r, l, sl, sl + len - 1, rand64());
            1: send_request(cmd, $urandom_range(0, 1023), $urandom_range(0, 1023),
                            $urandom_range(0, 1023), $urandom_range(0, 1023), rand64());
            2: send_request(cmd, l, r, sl, (sl + len) % DEPTH, rand64());
            default: send_request(cmd, l, r, sl, sl + len - 1, rand64());
        endcase
    endtask

    // Result checker; receiver stalls randomly or for a forced hold-off.
    initial begin : result_checker
        t_result ex;
        int      stall;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_cycles > 0) begin
                i_ready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            results_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result sum=%h status=%b",
                                               o_range_sum, o_status);
            end else begin
                ex = expected_q.pop_front();
                if (o_range_sum !== ex.sum || o_status !== ex.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch #%0d: sum exp %h got %h, status exp %b got %b",
                                 results_seen, ex.sum, o_range_sum, ex.status, o_status);
                end
            end
        end
    end

    task automatic test_writes_and_queries();
        send_request(CMD_QUERY, 0, 1023, 0, 0, 64'h0);
        send_request(CMD_WRITE, 0, 0, 0, 0, 64'h7fff_ffff_ffff_ffff);
        send_request(CMD_WRITE, 1023, 0, 1023, 1023, 64'h8000_0000_0000_0000);
        send_request(CMD_WRITE, 31, 1023, 0, 0, 64'hffff_ffff_ffff_ffff);
        send_request(CMD_QUERY, 0, 1023, 0, 0, 64'hffff_ffff_ffff_ffff);
        send_request(CMD_QUERY, 1023, 1023, 1023, 1023, 64'h0);
        send_request(CMD_QUERY, 5, 4, 0, 0, 64'h0);     // inverted range
    endtask

    task automatic test_range_adds();
        send_request(CMD_ADD, 0, 1023, 0, 0, 64'h7fff_ffff_ffff_ffff);  // wraps
        send_request(CMD_ADD, 3, 70, 1023, 0, 64'h5);
        send_request(CMD_ADD, 32, 63, 0, 0, 64'hffff_ffff_ffff_fffd);
        send_request(CMD_ADD, 9, 8, 0, 0, 64'h1);       // rejected
        send_request(CMD_WRITE, 40, 0, 0, 0, 64'h1234); // write over pending add
        send_request(CMD_QUERY, 0, 100, 0, 0, 64'h0);
        send_request(CMD_QUERY, 32, 63, 0, 0, 64'h0);
    endtask

    task automatic test_copies();
        send_request(CMD_COPY, 10, 80, 0, 70, 64'h0);     // overlapping, forward
        send_request(CMD_COPY, 0, 70, 10, 80, 64'h0);     // overlapping, backward
        send_request(CMD_COPY, 960, 1023, 0, 63, 64'h0);  // last blocks
        send_request(CMD_COPY, 0, 5, 10, 12, 64'h0);      // length mismatch
        send_request(CMD_COPY, 0, 5, 12, 7, 64'h0);       // bad source
        send_request(CMD_COPY, 7, 7, 7, 7, 64'h0);        // self copy
        send_request(CMD_QUERY, 0, 1023, 0, 0, 64'h0);
        send_request(CMD_QUERY, 950, 1023, 0, 0, 64'h0);
    endtask

    // Long receiver hold-off while requests keep coming.
    task automatic test_backpressure();
        hold_cycles = 400;
        for (int k = 0; k < 12; k++) begin
            send_request(t_cmd'(k % 4), k, k + 3, k + 5, k + 8, 64'(k), 1);
        end
    endtask

    task automatic test_random_mix();
        for (int k = 0; k < 1520; k++) send_random();
    endtask

    initial begin : run_ctl
        int drain;
        mismatches = 0; results_seen = 0; requests_sent = 0; hold_cycles = 0; bad_seen = 0;
        for (int i = 0; i < DEPTH; i++) elem_mem[i] = '0;
        for (int b = 0; b < NBLK; b++) begin
            blk_sum[b] = '0;
            blk_pend[b] = '0;
        end
        i_rst_n = 1'b0; i_valid = 1'b0; i_command = CMD_WRITE; i_left = '0; i_right = '0;
        i_source_left = '0; i_source_right = '0; i_value = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_writes_and_queries();
        test_range_adds();
        test_copies();
        test_backpressure();
        test_random_mix();
        i_valid <= 1'b0;
        drain = 0;
        while (expected_q.size() != 0 && drain < 2000000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (100) @(posedge i_clk);
        $display("Ran %0d requests (%0d rejected), %0d results checked, %0d mismatches.",
                 requests_sent, bad_seen, results_seen, mismatches);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("tb_range_add_copy_sum_engine_unit OK");
        end else begin
            $display("tb_range_add_copy_sum_engine_unit NOT OK");
        end
        $finish;
    end

    // Watchdog: sized for every request being a full-depth copy plus the longest
    // stalls, with a wide margin.
    initial begin : watchdog
        #200_000_000;
        $display("tb_range_add_copy_sum_engine_unit NOT OK");
        $finish;
    end

endmodule
